[hw/rtl/rtnh_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtnh_pkg
// Shared types, constants and saturation helpers for the ray/triangle
// nearest-hit block.
// ----------------------------------------------------------------------------
package rtnh_pkg;

    localparam int FACE_BITS_DEF = 20;
    localparam int COORD_W       = 32;
    localparam int DOT_W         = 64;
    localparam int DIST_W        = 31;
    localparam int CFG_IDX_W     = 3;
    localparam int STEP_W        = 5;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(24);
    localparam logic signed [DOT_W-1:0] DET_EPS = DOT_W'(11);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_MUL,
        S_NORM,
        S_CHECK,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] quot;
    } t_div_res;

    function automatic logic signed [COORD_W-1:0] f_sat33(input logic signed [COORD_W:0] x);
        logic signed [COORD_W-1:0] r;
        if (x[COORD_W] != x[COORD_W-1]) begin
            r = x[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            r = x[COORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] f_sat49(input logic signed [48:0] x);
        logic signed [COORD_W-1:0] r;
        if (x > 49'sh0_7FFF_FFFF) begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end else if (x < -49'sh0_8000_0000) begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            r = x[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/rtnh_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtnh_div
// Bit-serial restoring divider: floor(tn * 2^16 / det), saturated to 31 bits.
// ----------------------------------------------------------------------------
module rtnh_div (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic [rtnh_pkg::DOT_W-1:0]        i_num,
    input  wire logic [rtnh_pkg::DOT_W-1:0]        i_den,
    output rtnh_pkg::t_div_res                     o_res
);
    import rtnh_pkg::*;

    logic [DOT_W-1:0]  r_rem;
    logic [DOT_W-1:0]  r_den;
    logic [DIST_W-1:0] r_sh;
    logic [DIST_W-1:0] r_quot;
    logic [4:0]        r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DOT_W:0]    trial;
    logic              ge;
    logic              sat;

    assign trial = {r_rem, r_sh[DIST_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign sat   = {16'b0, i_num} >= {1'b0, i_den, 15'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_den <= i_den;
                if (sat) begin
                    r_quot <= '1;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= {15'b0, i_num[DOT_W-1:15]};
                    r_sh   <= {i_num[14:0], 16'b0};
                    r_cnt  <= 5'd31;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem  <= ge ? DOT_W'(trial - {1'b0, r_den}) : trial[DOT_W-1:0];
                r_sh   <= {r_sh[DIST_W-2:0], 1'b0};
                r_quot <= {r_quot[DIST_W-2:0], ge};
                r_cnt  <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.quot = r_quot;

endmodule
`default_nettype wire

[hw/rtl/ray_triangle_nearest_hit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit
// Nearest ray/triangle hit search over a stream of triangles, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Write the ray origin and direction through the cfg channel (index 0..5:
//   origin x,y,z then direction x,y,z); indexes 6 and 7 are ignored. The
//   cfg channel is always ready. Write only while no triangle is in flight.
//   Triangles enter on i_valid/o_ready, one item each. Each item passes
//   through an accept state, an edge state, the single shared 32x32
//   multiplier (24 products: 12 for the cross products and 12 for the dot
//   products), the normalize and check states, the bit-serial divider (31
//   steps and a handoff, with the steps skipped when the distance
//   saturates) if the item passes the checks, and an update state. o_ready
//   is high only between items.
//   On a triangle with i_last_tri set, one result leaves on o_valid/i_ready
//   and the search state clears. The result sits in an output register, so
//   the next triangle is taken while it waits; a later result stalls the
//   block until the receiver takes the earlier one.
//   Reset clears the ray registers to zero, drops any pending result and
//   clears the search state.
// ----------------------------------------------------------------------------
module ray_triangle_nearest_hit #(
    parameter int FACE_BITS = rtnh_pkg::FACE_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_valid,
    output      logic                                 o_cfg_ready,
    input  wire logic [rtnh_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [rtnh_pkg::COORD_W-1:0]         i_cfg_data,
    input  wire logic                                 i_valid,
    output      logic                                 o_ready,
    input  wire logic signed [rtnh_pkg::COORD_W-1:0]  i_ax,
    input  wire logic signed [rtnh_pkg::COORD_W-1:0]  i_ay,
    input  wire logic signed [rtnh_pkg::COORD_W-1:0]  i_az,
    input  wire logic signed [rtnh_pkg::COORD_W-1:0]  i_bx,
    input  wire logic signed [rtnh_pkg::COORD_W-1:0]  i_by_coord,
    input  wire logic signed [rtnh_pkg::COORD_W-1:0]  i_bz,
    input  wire logic signed [rtnh_pkg::COORD_W-1:0]  i_cx,
    input  wire logic signed [rtnh_pkg::COORD_W-1:0]  i_cy,
    input  wire logic signed [rtnh_pkg::COORD_W-1:0]  i_cz,
    input  wire logic [FACE_BITS-1:0]                 i_face_id,
    input  wire logic                                 i_last_tri,
    output      logic                                 o_valid,
    input  wire logic                                 i_ready,
    output      logic                                 o_hit,
    output      logic [rtnh_pkg::DIST_W-1:0]          o_hit_distance,
    output      logic [FACE_BITS-1:0]                 o_hit_face
);
    import rtnh_pkg::*;

    t_state r_state, n_state;

    logic signed [COORD_W-1:0] r_org [3];
    logic signed [COORD_W-1:0] r_dir [3];
    logic signed [COORD_W-1:0] r_va  [3];
    logic signed [COORD_W-1:0] r_vb  [3];
    logic signed [COORD_W-1:0] r_vc  [3];
    logic signed [COORD_W-1:0] r_ab  [3];
    logic signed [COORD_W-1:0] r_ac  [3];
    logic signed [COORD_W-1:0] r_off [3];
    logic signed [COORD_W-1:0] r_pq  [6];
    logic signed [DOT_W-1:0]   r_dot [4];
    logic [FACE_BITS-1:0]      r_face;
    logic                      r_last;
    logic [STEP_W-1:0]         r_step;
    logic signed [DOT_W-1:0]   r_prod;
    logic signed [DOT_W:0]     r_acc;
    logic [DOT_W-1:0]          r_det;
    logic signed [DOT_W-1:0]   r_un;
    logic signed [DOT_W-1:0]   r_vn;
    logic signed [DOT_W-1:0]   r_tn;
    logic                      r_pass;
    logic                      r_cand;
    logic [DIST_W-1:0]         r_dist;
    logic                      r_have;
    logic [DIST_W-1:0]         r_best;
    logic [FACE_BITS-1:0]      r_best_face;

    logic signed [COORD_W-1:0] opa, opb;
    logic [STEP_W-1:0]         j;
    logic signed [DOT_W:0]     cdiff;
    logic signed [DOT_W-1:0]   term;
    logic                      dfirst, dlast;
    logic [1:0]                dgrp;
    logic signed [DOT_W:0]     uv;
    logic                      chk_ok;
    logic                      div_start;
    t_div_res                  div_res;
    logic                      take;
    logic                      out_free;
    logic                      proceed;
    logic                      upd;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign take        = i_valid && o_ready;
    assign out_free    = !o_valid || i_ready;
    assign proceed     = (r_state == S_DONE) && (!r_last || out_free);
    assign upd         = r_cand && (!r_have || r_dist < r_best);
    assign j           = r_step - STEP_W'(1);
    assign cdiff       = r_acc - DOT_W'(0) - {r_prod[DOT_W-1], r_prod};
    assign term        = r_prod >>> 2;
    assign uv          = {r_un[DOT_W-1], r_un} + {r_vn[DOT_W-1], r_vn};
    assign chk_ok      = r_pass && !r_un[DOT_W-1] && !r_vn[DOT_W-1]
                         && ($unsigned(r_un) <= r_det)
                         && (uv <= $signed({1'b0, r_det}))
                         && !r_tn[DOT_W-1] && (r_tn != '0);
    assign div_start   = (r_state == S_CHECK) && chk_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (take) n_state = S_EDGE;
            S_EDGE:  n_state = S_MUL;
            S_MUL:   if (r_step == STEP_LAST) n_state = S_NORM;
            S_NORM:  n_state = S_CHECK;
            S_CHECK: n_state = chk_ok ? S_DIV : S_DONE;
            S_DIV:   if (div_res.done) n_state = S_DONE;
            S_DONE:  if (proceed) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org <= '{default: '0};
            r_dir <= '{default: '0};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_ORIGIN_X: r_org[0] <= i_cfg_data;
                REG_ORIGIN_Y: r_org[1] <= i_cfg_data;
                REG_ORIGIN_Z: r_org[2] <= i_cfg_data;
                REG_DIR_X:    r_dir[0] <= i_cfg_data;
                REG_DIR_Y:    r_dir[1] <= i_cfg_data;
                REG_DIR_Z:    r_dir[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        opa = r_dir[1];
        opb = r_ac[2];
        unique case (r_step)
            5'd0:  begin opa = r_dir[1]; opb = r_ac[2]; end
            5'd1:  begin opa = r_dir[2]; opb = r_ac[1]; end
            5'd2:  begin opa = r_dir[2]; opb = r_ac[0]; end
            5'd3:  begin opa = r_dir[0]; opb = r_ac[2]; end
            5'd4:  begin opa = r_dir[0]; opb = r_ac[1]; end
            5'd5:  begin opa = r_dir[1]; opb = r_ac[0]; end
            5'd6:  begin opa = r_off[1]; opb = r_ab[2]; end
            5'd7:  begin opa = r_off[2]; opb = r_ab[1]; end
            5'd8:  begin opa = r_off[2]; opb = r_ab[0]; end
            5'd9:  begin opa = r_off[0]; opb = r_ab[2]; end
            5'd10: begin opa = r_off[0]; opb = r_ab[1]; end
            5'd11: begin opa = r_off[1]; opb = r_ab[0]; end
            5'd12: begin opa = r_ab[0];  opb = r_pq[0]; end
            5'd13: begin opa = r_ab[1];  opb = r_pq[1]; end
            5'd14: begin opa = r_ab[2];  opb = r_pq[2]; end
            5'd15: begin opa = r_off[0]; opb = r_pq[0]; end
            5'd16: begin opa = r_off[1]; opb = r_pq[1]; end
            5'd17: begin opa = r_off[2]; opb = r_pq[2]; end
            5'd18: begin opa = r_dir[0]; opb = r_pq[3]; end
            5'd19: begin opa = r_dir[1]; opb = r_pq[4]; end
            5'd20: begin opa = r_dir[2]; opb = r_pq[5]; end
            5'd21: begin opa = r_ac[0];  opb = r_pq[3]; end
            5'd22: begin opa = r_ac[1];  opb = r_pq[4]; end
            5'd23: begin opa = r_ac[2];  opb = r_pq[5]; end
            default: ;
        endcase
    end

    always_comb begin
        dfirst = (j == 5'd12) || (j == 5'd15) || (j == 5'd18) || (j == 5'd21);
        dlast  = (j == 5'd14) || (j == 5'd17) || (j == 5'd20) || (j == 5'd23);
        priority if (j < 5'd15) begin
            dgrp = 2'd0;
        end else if (j < 5'd18) begin
            dgrp = 2'd1;
        end else if (j < 5'd21) begin
            dgrp = 2'd2;
        end else begin
            dgrp = 2'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (r_state == S_EDGE) begin
            r_step <= '0;
        end else if (r_state == S_MUL) begin
            r_step <= r_step + STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_va   <= '{i_ax, i_ay, i_az};
            r_vb   <= '{i_bx, i_by_coord, i_bz};
            r_vc   <= '{i_cx, i_cy, i_cz};
            r_face <= i_face_id;
            r_last <= i_last_tri;
        end
        if (r_state == S_EDGE) begin
            for (int k = 0; k < 3; k++) begin
                r_ab[k]  <= f_sat33({r_vb[k][COORD_W-1], r_vb[k]}
                                    - {r_va[k][COORD_W-1], r_va[k]});
                r_ac[k]  <= f_sat33({r_vc[k][COORD_W-1], r_vc[k]}
                                    - {r_va[k][COORD_W-1], r_va[k]});
                r_off[k] <= f_sat33({r_org[k][COORD_W-1], r_org[k]}
                                    - {r_va[k][COORD_W-1], r_va[k]});
            end
        end
        if (r_state == S_MUL) begin
            r_prod <= opa * opb;
            if (r_step != '0) begin
                if (j < 5'd12) begin
                    if (!j[0]) begin
                        r_acc <= {r_prod[DOT_W-1], r_prod};
                    end else begin
                        r_pq[j[3:1]] <= f_sat49(cdiff[DOT_W:16]);
                    end
                end else begin
                    if (dfirst) begin
                        r_acc <= {term[DOT_W-1], term};
                    end else if (dlast) begin
                        r_dot[dgrp] <= DOT_W'(r_acc + {term[DOT_W-1], term});
                    end else begin
                        r_acc <= r_acc + {term[DOT_W-1], term};
                    end
                end
            end
        end
        if (r_state == S_NORM) begin
            r_pass <= (r_dot[0] >= DET_EPS) || (r_dot[0] <= -DET_EPS);
            if (r_dot[0][DOT_W-1]) begin
                r_det <= $unsigned(-r_dot[0]);
                r_un  <= -r_dot[1];
                r_vn  <= -r_dot[2];
                r_tn  <= -r_dot[3];
            end else begin
                r_det <= $unsigned(r_dot[0]);
                r_un  <= r_dot[1];
                r_vn  <= r_dot[2];
                r_tn  <= r_dot[3];
            end
        end
        if (r_state == S_CHECK) begin
            r_cand <= 1'b0;
        end
        if (r_state == S_DIV && div_res.done) begin
            r_dist <= div_res.quot;
            r_cand <= (div_res.quot != '0);
        end
    end

    rtnh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ($unsigned(r_tn)),
        .i_den   (r_det),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_best      <= '1;
            r_best_face <= '0;
            o_valid     <= 1'b0;
        end else begin
            if (proceed && r_last) begin
                o_valid <= 1'b1;
            end else if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            if (proceed) begin
                if (r_last) begin
                    o_hit          <= r_have || upd;
                    o_hit_distance <= upd ? r_dist : (r_have ? r_best : '0);
                    o_hit_face     <= upd ? r_face : (r_have ? r_best_face : '0);
                    r_have         <= 1'b0;
                    r_best         <= '1;
                    r_best_face    <= '0;
                end else if (upd) begin
                    r_have      <= 1'b1;
                    r_best      <= r_dist;
                    r_best_face <= r_face;
                end
            end
        end
    end

`ifndef SYNTH
    a_mul_to_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_step == STEP_LAST) |=> (r_state == S_NORM))
        else $error("multiply sequence did not end in normalize");
    a_no_hit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_hit) |-> (o_hit_distance == '0 && o_hit_face == '0))
        else $error("miss result carries nonzero fields");
    a_best_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_have |-> (r_best != '0))
        else $error("stored hit has zero distance");
    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");
`endif

endmodule
`default_nettype wire
